### hw/rtl/assert_macros.svh
// Assertion helpers for the channel mixer.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define HCM_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hadamard_channel_mix: check failed");
// Next-cycle implication
`define HCM_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hadamard_channel_mix: check failed");
`else
`define HCM_ASSERT_IMP(label, cond, prop)
`define HCM_ASSERT_NXT(label, cond, prop)
`endif
`endif

### hw/rtl/hcm_pkg.sv
package hcm_pkg;

    // Port-level sample width and lane count
    localparam int SAMPLE_W  = 24;
    localparam int NUM_LANES = 8;
    // Butterfly stages for eight lanes
    localparam int BF_STAGES = 3;

    // Gain register, Q1.15
    localparam int GAIN_W    = 16;
    localparam int FRAC_BITS = 15;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd11585;
    localparam int ROUND_BIAS = 16384;

    // APB register map
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] REG_GAIN = 2'd0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_ch0;
        logic signed [SAMPLE_W-1:0] in_ch1;
        logic signed [SAMPLE_W-1:0] in_ch2;
        logic signed [SAMPLE_W-1:0] in_ch3;
        logic signed [SAMPLE_W-1:0] in_ch4;
        logic signed [SAMPLE_W-1:0] in_ch5;
        logic signed [SAMPLE_W-1:0] in_ch6;
        logic signed [SAMPLE_W-1:0] in_ch7;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_ch0;
        logic signed [SAMPLE_W-1:0] out_ch1;
        logic signed [SAMPLE_W-1:0] out_ch2;
        logic signed [SAMPLE_W-1:0] out_ch3;
        logic signed [SAMPLE_W-1:0] out_ch4;
        logic signed [SAMPLE_W-1:0] out_ch5;
        logic signed [SAMPLE_W-1:0] out_ch6;
        logic signed [SAMPLE_W-1:0] out_ch7;
    } frame_out_t;

endpackage

### hw/rtl/hadamard_channel_mix.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------
// frame    | frame_valid / frame_ready  | hcm_pkg::frame_in_t (8 x 24)
// mix      | mix_valid / mix_ready      | hcm_pkg::frame_out_t (8 x 24)
// apb      | psel / penable / pready    | gain at byte address 0
//
// One frame per cycle sustained while mix_ready stays high: every stage can load each cycle.
// mix_valid rises once an accepted frame reaches the output register, through three butterfly
// stages, one multiply stage and one round/saturate output stage.
// rst_n clears all stage valid bits and loads gain with 11585 (about 1/sqrt(8)).
// A stall on mix_ready backs up stage by stage; empty stages keep filling.
module hadamard_channel_mix #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcm_pkg::ADDR_W-1:0]     paddr,
    input  logic [hcm_pkg::DATA_W-1:0]     pwdata,
    output logic [hcm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // input frames
    input  logic                           frame_valid,
    output logic                           frame_ready,
    input  hcm_pkg::frame_in_t             frame,
    // mixed frames
    output logic                           mix_valid,
    input  logic                           mix_ready,
    output hcm_pkg::frame_out_t            mix
);

    import hcm_pkg::*;

    // Lane width after the butterflies, product width
    localparam int SW   = SAMPLE_BITS + BF_STAGES;
    localparam int PW   = SW + GAIN_W + 1;
    localparam int NSTG = BF_STAGES + 2;
    localparam int MUL_STG = BF_STAGES;
    localparam int OUT_STG = BF_STAGES + 1;

    localparam logic signed [PW-1:0] SAT_HI =
        {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO =
        {{(PW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Gain register
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_reg;
    logic              gain_wr;

    assign gain_wr = psel && penable && pwrite && (paddr == REG_GAIN);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (gain_wr)
        begin
            gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_GAIN)
        begin
            prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and load enables
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] stage_load;

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        stage_load[NSTG-1] = !vld_reg[NSTG-1] || mix_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stage_load[k] = !vld_reg[k] || stage_load[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = stage_load[0] ? frame_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = stage_load[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign frame_ready = stage_load[0];
    assign mix_valid   = vld_reg[OUT_STG];

    // ------------------------------------------------------------------
    // Input lanes: keep SAMPLE_BITS bits, sign-extend to SW
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0]    lane_raw [NUM_LANES];
    logic [SAMPLE_BITS-1:0] lane_cut [NUM_LANES];

    assign lane_raw[0] = frame.in_ch0;
    assign lane_raw[1] = frame.in_ch1;
    assign lane_raw[2] = frame.in_ch2;
    assign lane_raw[3] = frame.in_ch3;
    assign lane_raw[4] = frame.in_ch4;
    assign lane_raw[5] = frame.in_ch5;
    assign lane_raw[6] = frame.in_ch6;
    assign lane_raw[7] = frame.in_ch7;

    // Butterfly stage inputs and registers
    logic signed [SW-1:0] bf_in  [BF_STAGES][NUM_LANES];
    logic signed [SW-1:0] bf_reg [BF_STAGES][NUM_LANES];

    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane_in
        if (SAMPLE_BITS <= SAMPLE_W)
        begin : g_narrow
            assign lane_cut[c] = lane_raw[c][SAMPLE_BITS-1:0];
        end
        else
        begin : g_wide
            assign lane_cut[c] = {{(SAMPLE_BITS-SAMPLE_W){1'b0}}, lane_raw[c]};
        end
        assign bf_in[0][c] = {{BF_STAGES{lane_cut[c][SAMPLE_BITS-1]}}, lane_cut[c]};
    end

    // ------------------------------------------------------------------
    // Butterfly stages: pairs at distance 1, 2, 4 become sum and difference
    // ------------------------------------------------------------------
    for (genvar s = 0; s < BF_STAGES; s++)
    begin : g_bf
        localparam int DIST = 1 << s;
        if (s > 0)
        begin : g_chain
            for (genvar c = 0; c < NUM_LANES; c++)
            begin : g_link
                assign bf_in[s][c] = bf_reg[s-1][c];
            end
        end
        for (genvar c = 0; c < NUM_LANES; c++)
        begin : g_pair
            localparam int PARTNER = c ^ DIST;
            logic signed [SW-1:0] bf_next;
            if ((PARTNER < CHANNELS) && (c < CHANNELS))
            begin : g_active
                if ((c & DIST) == 0)
                begin : g_sum
                    assign bf_next = bf_in[s][c] + bf_in[s][PARTNER];
                end
                else
                begin : g_diff
                    assign bf_next = bf_in[s][PARTNER] - bf_in[s][c];
                end
            end
            else
            begin : g_pass
                // no partner in range: lane passes unchanged
                assign bf_next = bf_in[s][c];
            end

            always_ff @(posedge clk)
            begin
                if (stage_load[s])
                begin
                    bf_reg[s][c] <= bf_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Gain multiply, then round and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [PW-1:0]          gain_s;
    logic signed [PW-1:0]          prod_reg [NUM_LANES];
    logic signed [PW-1:0]          prod_rnd [NUM_LANES];
    logic signed [PW-1:0]          prod_q   [NUM_LANES];
    logic        [SAMPLE_BITS-1:0] sat_next [NUM_LANES];
    logic        [SAMPLE_BITS-1:0] out_reg  [NUM_LANES];
    logic        [SAMPLE_W-1:0]    mix_lane [NUM_LANES];

    assign gain_s = {{(PW-GAIN_W){1'b0}}, gain_reg};

    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_scale
        always_ff @(posedge clk)
        begin
            if (stage_load[MUL_STG])
            begin
                prod_reg[c] <= PW'(bf_reg[BF_STAGES-1][c]) * gain_s;
            end
        end

        // add half an LSB, floor by 2^15, clamp to the sample range
        assign prod_rnd[c] = prod_reg[c] + PW'(ROUND_BIAS);
        assign prod_q[c]   = prod_rnd[c] >>> FRAC_BITS;

        always_comb
        begin
            if (prod_q[c] > SAT_HI)
                sat_next[c] = SAT_HI[SAMPLE_BITS-1:0];
            else if (prod_q[c] < SAT_LO)
                sat_next[c] = SAT_LO[SAMPLE_BITS-1:0];
            else
                sat_next[c] = prod_q[c][SAMPLE_BITS-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (stage_load[OUT_STG])
            begin
                out_reg[c] <= sat_next[c];
            end
        end

        // unused lanes read zero; bits above SAMPLE_BITS are zero
        if (c >= CHANNELS)
        begin : g_unused
            assign mix_lane[c] = '0;
        end
        else if (SAMPLE_BITS < SAMPLE_W)
        begin : g_pad
            assign mix_lane[c] = {{(SAMPLE_W-SAMPLE_BITS){1'b0}}, out_reg[c]};
        end
        else
        begin : g_trim
            assign mix_lane[c] = out_reg[c][SAMPLE_W-1:0];
        end
    end

    assign mix.out_ch0 = mix_lane[0];
    assign mix.out_ch1 = mix_lane[1];
    assign mix.out_ch2 = mix_lane[2];
    assign mix.out_ch3 = mix_lane[3];
    assign mix.out_ch4 = mix_lane[4];
    assign mix.out_ch5 = mix_lane[5];
    assign mix.out_ch6 = mix_lane[6];
    assign mix.out_ch7 = mix_lane[7];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "assert_macros.svh"

    // with the output stage empty the whole pipe can move
    `HCM_ASSERT_IMP(a_ready_when_drained, !mix_valid, frame_ready)
    // an item blocked in the multiply stage is not dropped
    `HCM_ASSERT_NXT(a_hold_stalled, vld_reg[MUL_STG] && !stage_load[OUT_STG], vld_reg[MUL_STG])
    // a product moving on shows up as a result
    `HCM_ASSERT_NXT(a_advance_out, vld_reg[MUL_STG] && stage_load[OUT_STG], mix_valid)
    // gain takes the written value
    `HCM_ASSERT_NXT(a_gain_write, gain_wr, gain_reg == $past(pwdata[GAIN_W-1:0]))

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hcm_pkg::*;

    localparam int FRAME_BITS = NUM_LANES * SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint LANE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint LANE_LO = -LANE_HI - 1;
    localparam int LONG_HOLD = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    logic frame_valid = 1'b0;
    logic frame_ready;
    frame_in_t frame = '0;
    logic mix_valid;
    logic mix_ready = 1'b0;
    frame_out_t mix;

    // frames waiting to be sent, mixes waiting to come back
    frame_in_t frames_todo[$];
    frame_out_t mixes_due[$];

    logic [GAIN_W-1:0] gain_now = GAIN_RESET;
    int frames_total = 0;
    int mixes_seen = 0;
    int failures = 0;
    int idle_odds = 4;
    int hold_reqs = 0;
    int holds_done;
    int gap_left;
    int stall_left;
    int hold_left;
    int quiet_cycles = 0;

    hadamard_channel_mix dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .mix_valid   (mix_valid),
        .mix_ready   (mix_ready),
        .mix         (mix)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Butterfly network, then scale by gain, round half up and clamp per lane
    function automatic frame_out_t mix_frame(frame_in_t f, logic [GAIN_W-1:0] g);
        longint lane[NUM_LANES];
        longint x;
        longint y;
        longint q;
        logic [FRAME_BITS-1:0] flat_in;
        logic [FRAME_BITS-1:0] flat_out;
        flat_in = f;
        flat_out = '0;
        for (int c = 0; c < NUM_LANES; c++)
            lane[c] = longint'($signed(flat_in[(NUM_LANES-1-c)*SAMPLE_W +: SAMPLE_W]));
        for (int w = 1; w < NUM_LANES; w *= 2)
        begin
            for (int base = 0; base < NUM_LANES; base += 2 * w)
            begin
                for (int k = 0; k < w; k++)
                begin
                    x = lane[base + k];
                    y = lane[base + k + w];
                    lane[base + k] = x + y;
                    lane[base + k + w] = x - y;
                end
            end
        end
        for (int c = 0; c < NUM_LANES; c++)
        begin
            // arithmetic shift of a signed value floors
            q = (lane[c] * longint'({1'b0, g}) + ROUND_BIAS) >>> FRAC_BITS;
            if (q > LANE_HI)
                q = LANE_HI;
            else if (q < LANE_LO)
                q = LANE_LO;
            flat_out[(NUM_LANES-1-c)*SAMPLE_W +: SAMPLE_W] = q[SAMPLE_W-1:0];
        end
        return frame_out_t'(flat_out);
    endfunction

    // Mostly full-range samples, some small ones that avoid clamping, some extremes
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick < 5)
            return SAMPLE_W'($urandom);
        if (pick < 8)
            return SAMPLE_W'($urandom_range(4000, 0) - 2000);
        if (pick == 8)
            return S_MAX;
        return S_MIN;
    endfunction

    task automatic queue_frame(input frame_in_t f);
        frames_todo.insert(frames_todo.size(), f);
        frames_total++;
    endtask

    task automatic queue_random(input int count);
        logic [FRAME_BITS-1:0] flat;
        for (int n = 0; n < count; n++)
        begin
            for (int c = 0; c < NUM_LANES; c++)
                flat[c*SAMPLE_W +: SAMPLE_W] = rand_sample();
            queue_frame(frame_in_t'(flat));
        end
    endtask

    // Wait for the pipeline to empty, then write the gain over APB
    task automatic write_gain(input logic [GAIN_W-1:0] value);
        while (mixes_seen < frames_total)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_GAIN;
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gain_now = value;
    endtask

    // Stimulus sequence
    initial
    begin
        logic [FRAME_BITS-1:0] flat;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames at the reset gain: zero, extremes, alternation, impulses, all +1 and all -1
        queue_frame(frame_in_t'('0));
        queue_frame(frame_in_t'({NUM_LANES{S_MAX}}));
        queue_frame(frame_in_t'({NUM_LANES{S_MIN}}));
        queue_frame(frame_in_t'({(NUM_LANES/2){S_MAX, S_MIN}}));
        queue_frame(frame_in_t'({(NUM_LANES/2){S_MIN, S_MAX}}));
        for (int c = 0; c < NUM_LANES; c++)
        begin
            flat = '0;
            flat[(NUM_LANES-1-c)*SAMPLE_W +: SAMPLE_W] = (c % 2) ? S_MIN : S_MAX;
            queue_frame(frame_in_t'(flat));
        end
        queue_frame(frame_in_t'({NUM_LANES{SAMPLE_W'(1)}}));
        queue_frame(frame_in_t'({NUM_LANES{SAMPLE_W'(-1)}}));
        flat = '0;
        flat[FRAME_BITS-1 -: SAMPLE_W] = SAMPLE_W'(1);
        queue_frame(frame_in_t'(flat));

        // gain of one half: exact halves round toward plus infinity
        write_gain(GAIN_W'(16384));
        foreach (flat[i])
            flat[i] = 1'b0;
        flat[FRAME_BITS-1 -: SAMPLE_W] = SAMPLE_W'(1);
        queue_frame(frame_in_t'(flat));
        flat[FRAME_BITS-1 -: SAMPLE_W] = SAMPLE_W'(-1);
        queue_frame(frame_in_t'(flat));
        flat[FRAME_BITS-1 -: SAMPLE_W] = SAMPLE_W'(3);
        queue_frame(frame_in_t'(flat));
        flat[FRAME_BITS-1 -: SAMPLE_W] = SAMPLE_W'(-3);
        queue_frame(frame_in_t'(flat));
        queue_random(150);

        // unity gain; receiver holds off long enough to back up the input
        write_gain(GAIN_W'(32768));
        queue_random(250);
        hold_reqs++;

        write_gain('0);
        queue_random(200);

        // largest register value is used as a plain multiplier
        write_gain('1);
        queue_random(200);

        write_gain(GAIN_W'(1));
        idle_odds = 3;
        queue_random(200);

        // a stretch without idling on either side
        write_gain(GAIN_W'($urandom_range(32768, 0)));
        idle_odds = 0;
        queue_random(250);

        write_gain(GAIN_RESET);
        idle_odds = 5;
        queue_random(300);

        // last part runs at full rate
        write_gain(GAIN_W'($urandom_range(32767, 1)));
        idle_odds = 0;
        queue_random(250);

        while (mixes_seen < frames_total)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mixes_due.size() != 0)
        begin
            $error("mix: %0d frames never came back", mixes_due.size());
            failures++;
        end
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Frame driver with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!frame_valid || frame_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                frame_valid <= 1'b0;
            end
            else if (idle_odds != 0 && frames_todo.size() != 0 && $urandom % idle_odds == 0)
            begin
                gap_left <= $urandom_range(5, 0);
                frame_valid <= 1'b0;
            end
            else if (frames_todo.size() != 0)
            begin
                frame <= frames_todo.pop_front();
                frame_valid <= 1'b1;
            end
            else
                frame_valid <= 1'b0;
        end
    end

    // Mix receiver: random stalls plus the requested long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            mix_ready <= 1'b0;
        end
        else if (holds_done != hold_reqs)
        begin
            holds_done <= holds_done + 1;
            hold_left <= LONG_HOLD - 1;
            mix_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            mix_ready <= 1'b0;
        end
        else if (idle_odds != 0 && $urandom % idle_odds == 0)
        begin
            stall_left <= $urandom_range(5, 0);
            mix_ready <= 1'b0;
        end
        else
            mix_ready <= 1'b1;
    end

    // Monitor: predict on frame accept, check on mix accept
    always @(posedge clk)
    begin
        frame_out_t want;
        logic [FRAME_BITS-1:0] flat_want;
        logic [FRAME_BITS-1:0] flat_got;
        if (rst_n)
        begin
            if (frame_valid && frame_ready)
                mixes_due.insert(mixes_due.size(), mix_frame(frame, gain_now));
            if (mix_valid && mix_ready)
            begin
                mixes_seen++;
                if (mixes_due.size() == 0)
                begin
                    $error("mix: item with no frame pending");
                    failures++;
                end
                else
                begin
                    want = mixes_due.pop_front();
                    flat_want = want;
                    flat_got = mix;
                    for (int c = 0; c < NUM_LANES; c++)
                    begin
                        if (flat_got[c*SAMPLE_W +: SAMPLE_W] !== flat_want[c*SAMPLE_W +: SAMPLE_W])
                        begin
                            $error("out_ch%0d: expected %0d, got %0d", NUM_LANES - 1 - c,
                                   $signed(flat_want[c*SAMPLE_W +: SAMPLE_W]),
                                   $signed(flat_got[c*SAMPLE_W +: SAMPLE_W]));
                            failures++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || psel || (frame_valid && frame_ready) || (mix_valid && mix_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
